/* hw/rtl/sha_pkg.sv */
// SHA-256 hasher package: controller states, command/status structs, initial
// hash values, round constants, padding constants and the rotate-right helper.
package sha_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       take_byte;  // write input byte at fill position
        logic       pad_write;  // write one padding/length byte
        logic       pad_mark;   // padding byte is the 0x80 marker
        logic       pad_len;    // this block carries the length field
        logic       load;       // load working vars, start schedule
        logic       round;      // run one round
        logic       fold;       // add working vars into chain
        logic       restart;    // chain/fill/count back to initial
        logic       shift_out;  // advance digest word
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } t_status;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* hw/rtl/sha256_message_hasher.sv */
// SHA-256 message hasher top level: joins controller and datapath.
// Uses sha_pkg, sha_ctrl, sha_datapath.
//
// Takes one byte per word while idle, packed straight into the 16-word
// schedule window. Each full 64-byte block then needs a load, 64 rounds
// and a fold, during which input stalls; the shared round unit runs one
// round per cycle. End of message writes the padding one byte per cycle,
// runs one or two more compressions, then emits eight digest words, state
// word 0 first, with o_digest_last on the eighth. Output words wait in the
// chain register while i_stall is high. The chain state then returns to
// the initial values for the next message.
module sha256_message_hasher import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);

    t_cmd    cmd;
    t_status status;

    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .i_status         (status),
        .i_out_stall      (i_stall),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_last           (o_digest_last),
        .o_cmd            (cmd)
    );

    sha_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .o_status    (status),
        .o_head_word (o_digest_word)
    );

endmodule

/* hw/rtl/sha_datapath.sv */
// SHA-256 datapath: message schedule window (also the block store), working
// variables, chain words and bit counter. Uses sha_pkg.
module sha_datapath import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_status     o_status,
    output logic [31:0] o_head_word
);

    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_round;
    logic [7:0]  pad_val;
    logic [2:0]  len_sel;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [31:0] s0, s1, w_new, t1, t2, w_cur;
    logic [31:0] e, a;

    // padding byte: marker, then zeros, length bytes at 56..63 of the last block
    assign len_sel = r_fill[2:0];
    always_comb begin
        if (i_cmd.pad_mark) pad_val = PAD_BYTE;
        else if (i_cmd.pad_len && r_fill >= LEN_POS) pad_val = r_bits[{~len_sel, 3'b000} +: 8];
        else pad_val = '0;
    end

    assign wr_en   = i_cmd.take_byte || i_cmd.pad_write;
    assign wr_byte = i_cmd.take_byte ? i_data_byte : pad_val;

    assign w_cur = r_w[0];
    assign s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = s1 + r_w[9] + s0 + r_w[0];
    assign e = r_v[4];
    assign a = r_v[0];
    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + K_ROUND[r_round] + w_cur;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    // bytes land big-endian straight in the schedule window; every block
    // rewrites all 64 byte lanes before its compression starts
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_byte;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            if (i_cmd.take_byte) begin
                r_fill <= r_fill + 6'd1;
                r_bits <= r_bits + 64'd8;
            end else if (i_cmd.pad_write) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.load) r_round <= '0;
            else if (i_cmd.round) r_round <= r_round + 6'd1;
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end else if (i_cmd.shift_out) begin
                for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                r_h[7] <= r_h[0];
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.round_last = (r_round == 6'd63);
    assign o_head_word         = r_h[0];

endmodule

/* hw/rtl/sha_ctrl.sv */
// SHA-256 controller: sequences byte intake, block compression, padding
// and digest output. Uses sha_pkg.
module sha_ctrl import sha_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_byte_present,
    input  logic    i_end_of_message,
    input  t_status i_status,
    input  logic    i_out_stall,
    output logic    o_stall,
    output logic    o_valid,
    output logic    o_last,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic       r_final, n_final;   // padding pending after this block
    logic       r_marker, n_marker; // 0x80 already written
    logic [2:0] r_cnt, n_cnt;
    logic       acc;

    assign acc = i_valid && !o_stall;

    always_comb begin
        n_state  = r_state;
        n_final  = r_final;
        n_marker = r_marker;
        n_cnt    = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_final  = i_end_of_message;
                    n_marker = 1'b0;
                    if (i_byte_present && i_status.fill == 6'd63) n_state = ST_LOAD;
                    else if (i_end_of_message) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                n_marker = 1'b1;
                // marker landing in the length area forces a second block
                if (!r_marker) n_final = (i_status.fill >= LEN_POS);
                if (i_status.fill == 6'd63) n_state = ST_LOAD;
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (i_status.round_last) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_final) begin
                    n_state = ST_PAD;
                    n_final = 1'b0;
                end else if (r_marker) begin
                    n_state = ST_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The pad state writes 0x80 first, then zeros up to 55, then length bytes.
    // A block whose marker sits at 56 or above gets zeros only, and a second
    // block with zeros and the length follows.

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        o_last  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall         = 1'b0;
                o_cmd.take_byte = acc && i_byte_present;
            end
            ST_PAD: begin
                o_cmd.pad_write = 1'b1;
                o_cmd.pad_mark  = !r_marker;
                o_cmd.pad_len   = r_marker && !r_final;
            end
            ST_LOAD:  o_cmd.load  = 1'b1;
            ST_ROUND: o_cmd.round = 1'b1;
            ST_FOLD:  o_cmd.fold  = 1'b1;
            ST_EMIT: begin
                o_valid         = 1'b1;
                o_last          = (r_cnt == 3'd7);
                o_cmd.shift_out = !i_out_stall;
                o_cmd.restart   = !i_out_stall && (r_cnt == 3'd7);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_final  <= 1'b0;
            r_marker <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_final  <= n_final;
            r_marker <= n_marker;
            r_cnt    <= n_cnt;
        end
    end

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_out_stall && r_cnt == 3'd7) |=> r_state == ST_IDLE)
        else $error("emit did not end after eight words");
    a_round_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && i_status.round_last) |=> r_state == ST_FOLD)
        else $error("round count lost");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_byte |-> r_state == ST_IDLE)
        else $error("byte taken while busy");

endmodule

/* tb/testbench.sv */
// Testbench for sha256_message_hasher: drives byte words and end markers,
// predicts digests with a SHA-256 model of its own and checks every word.
// Depends on sha_pkg (K_ROUND, H_INIT, PAD_BYTE) and the RTL.
module testbench;
    import sha_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic        o_digest_last;

    sha256_message_hasher dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] msg_bits;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } t_digest_word;
    t_digest_word digest_queue[$];

    int  errors = 0;
    int  cycles = 0;
    int  digests_seen = 0;
    localparam int CYCLE_LIMIT = 400000;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + K_ROUND[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
        fill = '0;
        msg_bits = '0;
    endtask

    // advance the hash by one accepted word, queue a digest on end of message
    task automatic hash_word(logic [7:0] data, logic present, logic eom);
        int pos;
        if (present) begin
            blk[fill] = data;
            msg_bits += 64'd8;
            fill++;
            if (fill == 0) compress();
        end
        if (!eom) return;
        pos = fill;
        blk[pos] = PAD_BYTE;
        pos++;
        if (pos > 56) begin
            while (pos < 64) blk[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < 56) blk[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[8*(7-i) +: 8];
        compress();
        for (int i = 0; i < 8; i++) digest_queue.push_back('{chain[i], i == 7});
        restart_hash();
    endtask

    // one word through the handshake, then a random gap
    task automatic send(logic [7:0] data, logic present, logic eom);
        int gap;
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hash_word(data, present, eom);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output side: random stall (none while digests_seen % 4 == 1), check each accepted digest word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: digest_word expected none actual %h", $time, o_digest_word);
                    errors++;
                end else begin
                    t_digest_word exp_w;
                    exp_w = digest_queue.pop_front();
                    if (o_digest_word !== exp_w.word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, exp_w.word, o_digest_word);
                        errors++;
                    end
                    if (o_digest_last !== exp_w.last) begin
                        $display("%0t: digest_last expected %b actual %b",
                                 $time, exp_w.last, o_digest_last);
                        errors++;
                    end
                    if (exp_w.last) digests_seen++;
                end
            end
            i_stall <= (digests_seen % 4 == 1) ? 1'b0 :
                       ($urandom_range(0, 99) < 25) ? 1'b1 :
                       ($urandom_range(0, 99) < 2);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // directed table: {byte, present, end, first digest word or 0 if predicted}
    typedef struct {
        logic [7:0]  data;
        logic        present;
        logic        eom;
        logic [31:0] known_first;
    } t_row;

    t_row directed [] = '{
        '{8'h00, 1'b0, 1'b0, 32'h0},          // neither byte nor end: ignored
        '{8'h00, 1'b0, 1'b1, 32'he3b0c442},   // empty message
        '{8'h61, 1'b1, 1'b0, 32'h0},          // "abc"
        '{8'h62, 1'b1, 1'b0, 32'h0},
        '{8'h63, 1'b1, 1'b1, 32'hba7816bf},   // byte and end together
        '{8'hff, 1'b1, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 32'h0},
        '{8'h5a, 1'b0, 1'b0, 32'h0},          // ignored, data bits set
        '{8'ha5, 1'b1, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 32'h0}           // bare end after bytes
    };

    // a message of n random bytes, ended on the last byte or by a bare marker
    task automatic send_message(int n);
        bit bare;
        bare = (n == 0) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n; i++)
            send(8'($urandom_range(0, 255)), 1'b1, !bare && i == n - 1);
        if (bare) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int lens [] = '{55, 56, 63, 64};
        restart_hash();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            send(directed[k].data, directed[k].present, directed[k].eom);
            if (directed[k].known_first != 0 && digest_queue[$-7].word
                    !== directed[k].known_first) begin
                $display("%0t: known digest expected %h predicted %h", $time,
                         directed[k].known_first, digest_queue[$-7].word);
                errors++;
            end
        end

        // pad boundaries: one or two final blocks
        foreach (lens[k]) send_message(lens[k]);
        wait_drain();   // sender holds off until every digest word is in

        // random: mostly short messages, a few noise words
        for (int n = 0; n < 4; n++) begin
            if ($urandom_range(0, 3) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_message($urandom_range(0, 9) < 8 ? $urandom_range(0, 4)
                                                  : $urandom_range(5, 12));
        end
        wait_drain();
        repeat (200) @(posedge i_clk);

        if (errors == 0 && digest_queue.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
